// ===== src/dad_pkg.sv =====
// Shared widths, register indexes, reset values and stage types for the anchor decoder.
package dad_pkg;

  localparam int CLASS_COUNT     = 80;
  localparam int COORD_FRAC_BITS = 4;
  localparam int MAX_FRAME_DIM   = 4096;

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 7;
  localparam int PIX_W   = 12;
  localparam int MASK_W  = 64;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int SCALE_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Doubled corner minus shifted pad, and its product with the inverse scale.
  localparam int PAD_SH_W = PIX_W + COORD_FRAC_BITS + 1;
  localparam int D_W = ((COORD_W + 2 > PAD_SH_W) ? COORD_W + 2 : PAD_SH_W) + 2;
  localparam int P_W = D_W + SCALE_W + 1;
  localparam int PROD_SHIFT = COORD_FRAC_BITS + 17;
  localparam int V_W = P_W - PROD_SHIFT;

  localparam logic [PIX_W-1:0] CAP_MAX = PIX_W'(MAX_FRAME_DIM - 1);

  localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_MASK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAX_Y    = 3'd6;

  localparam logic [SCORE_W-1:0] RST_CONF_THRESHOLD = 16'd26214;
  localparam logic [MASK_W-1:0]  RST_CLASS_MASK     = 64'd175;
  localparam logic [PIX_W-1:0]   RST_PAD            = 12'd0;
  localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE  = 24'd65536;
  localparam logic [PIX_W-1:0]   RST_FRAME_MAX      = 12'd639;

  typedef struct packed {
    logic [SCORE_W-1:0] conf_threshold;
    logic [MASK_W-1:0]  class_mask;
    logic [PIX_W-1:0]   pad_x;
    logic [PIX_W-1:0]   pad_y;
    logic [SCALE_W-1:0] inverse_scale;
    logic [PIX_W-1:0]   frame_max_x;
    logic [PIX_W-1:0]   frame_max_y;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] box_width;
    logic signed [COORD_W-1:0] box_height;
    logic [SCORE_W-1:0]        score;
    logic [CLASS_W-1:0]        win_class;
  } det_t;

endpackage

// ===== src/dad_cfg.sv =====
// Configuration register file written through the index/data channel.
module dad_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data,
  output dad_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= dad_pkg::RST_CONF_THRESHOLD;
      cfg.class_mask     <= dad_pkg::RST_CLASS_MASK;
      cfg.pad_x          <= dad_pkg::RST_PAD;
      cfg.pad_y          <= dad_pkg::RST_PAD;
      cfg.inverse_scale  <= dad_pkg::RST_INVERSE_SCALE;
      cfg.frame_max_x    <= dad_pkg::RST_FRAME_MAX;
      cfg.frame_max_y    <= dad_pkg::RST_FRAME_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        dad_pkg::REG_CONF_THRESHOLD: cfg.conf_threshold <= cfg_data[dad_pkg::SCORE_W-1:0];
        dad_pkg::REG_CLASS_MASK:     cfg.class_mask     <= cfg_data[dad_pkg::MASK_W-1:0];
        dad_pkg::REG_PAD_X:          cfg.pad_x          <= cfg_data[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_PAD_Y:          cfg.pad_y          <= cfg_data[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_INVERSE_SCALE:  cfg.inverse_scale  <= cfg_data[dad_pkg::SCALE_W-1:0];
        dad_pkg::REG_FRAME_MAX_X:    cfg.frame_max_x    <= cfg_data[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_FRAME_MAX_Y:    cfg.frame_max_y    <= cfg_data[dad_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dad_winner.sv =====
// Running best-class tracker and the register that holds a finished anchor's detection.
module dad_winner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               advance,
  input  logic signed [dad_pkg::COORD_W-1:0] center_x,
  input  logic signed [dad_pkg::COORD_W-1:0] center_y,
  input  logic signed [dad_pkg::COORD_W-1:0] box_width,
  input  logic signed [dad_pkg::COORD_W-1:0] box_height,
  input  logic [dad_pkg::SCORE_W-1:0]        class_score,
  input  logic [dad_pkg::CLASS_W-1:0]        class_index,
  input  logic                               last_class,
  input  dad_pkg::cfg_t                      cfg,
  output logic                               det_valid,
  output dad_pkg::det_t                      det
);

  logic [dad_pkg::SCORE_W-1:0] lead_score;
  logic [dad_pkg::CLASS_W-1:0] lead_class;
  logic                        lead_found;

  logic                        enabled;
  logic                        win;
  logic [dad_pkg::SCORE_W-1:0] lead_score_next;
  logic [dad_pkg::CLASS_W-1:0] lead_class_next;
  logic                        lead_found_next;
  logic                        emit;

  always_comb begin
    enabled = (int'(class_index) < dad_pkg::MASK_W) &&
              (int'(class_index) < dad_pkg::CLASS_COUNT) &&
              cfg.class_mask[class_index[dad_pkg::MASK_IDX_W-1:0]];
    // Strict compare: a zero score never wins and ties keep the earlier class.
    win             = enabled && (class_score > lead_score);
    lead_score_next = win ? class_score : lead_score;
    lead_class_next = win ? class_index : lead_class;
    lead_found_next = lead_found | win;
    emit            = lead_found_next && (lead_score_next >= cfg.conf_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_score <= '0;
      lead_class <= '0;
      lead_found <= 1'b0;
    end else if (fire) begin
      if (last_class) begin
        lead_score <= '0;
        lead_class <= '0;
        lead_found <= 1'b0;
      end else begin
        lead_score <= lead_score_next;
        lead_class <= lead_class_next;
        lead_found <= lead_found_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_valid <= 1'b0;
    end else if (fire && last_class) begin
      det_valid <= emit;
    end else if (advance) begin
      det_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_class) begin
      det.center_x   <= center_x;
      det.center_y   <= center_y;
      det.box_width  <= box_width;
      det.box_height <= box_height;
      det.score      <= lead_score_next;
      det.win_class  <= lead_class_next;
    end
  end

endmodule

// ===== src/dad_corner.sv =====
// One box corner: letterbox unpad, inverse-scale multiply, then truncate and clamp.
module dad_corner (
  input  logic                               clk,
  input  logic                               en_mul,
  input  logic                               en_out,
  input  logic                               add_size,
  input  logic signed [dad_pkg::COORD_W-1:0] center,
  input  logic signed [dad_pkg::COORD_W-1:0] size,
  input  logic [dad_pkg::PIX_W-1:0]          pad,
  input  logic [dad_pkg::SCALE_W-1:0]        inv_scale,
  input  logic [dad_pkg::PIX_W-1:0]          lim,
  output logic [dad_pkg::PIX_W-1:0]          corner
);

  localparam int D_W = dad_pkg::D_W;
  localparam int P_W = dad_pkg::P_W;
  localparam int V_W = dad_pkg::V_W;

  logic signed [D_W-1:0] c2;
  logic signed [D_W-1:0] sz;
  logic signed [D_W-1:0] pd;
  logic signed [D_W-1:0] d;
  logic signed [P_W-1:0] prod_next;
  logic signed [P_W-1:0] prod;
  logic [V_W-1:0]                 v;
  logic [dad_pkg::PIX_W-1:0]      cap;
  logic [dad_pkg::PIX_W-1:0]      corner_next;

  always_comb begin
    // Corner at doubled scale keeps the half-size exact.
    c2 = D_W'(center) <<< 1;
    sz = D_W'(size);
    pd = D_W'(signed'({1'b0, pad})) <<< (dad_pkg::COORD_FRAC_BITS + 1);
    d  = (add_size ? (c2 + sz) : (c2 - sz)) - pd;
    prod_next = P_W'(d) * P_W'(signed'({1'b0, inv_scale}));
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    v   = prod[P_W-1:dad_pkg::PROD_SHIFT];
    cap = (lim > dad_pkg::CAP_MAX) ? dad_pkg::CAP_MAX : lim;
    if (prod[P_W-1]) begin
      corner_next = '0;
    end else if (v > V_W'(cap)) begin
      corner_next = cap;
    end else begin
      corner_next = v[dad_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      corner <= corner_next;
    end
  end

endmodule

// ===== src/detection_anchor_decode.sv =====
// Top level of the anchor decoder: score tracking, registers and the box corner pipeline.
// A detection passes the winner, product and clamp registers in turn before it is offered.
// Throughput: one score item per cycle while s_axis_tready is high; the best-score compare and the three-register
// result pipeline (winner, product, clamp) each advance once per cycle while unblocked.
// Reset: synchronous; clears the running best, empties the pipeline and loads the
// registers with their reset values (threshold 26214, mask 175, scale 1.0, limits 639).
module detection_anchor_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // center_x[15:0], center_y[31:16], box_width[47:32], box_height[63:48], class_score[79:64]
  input  logic [79:0]                         s_axis_tdata,
  // class_index[6:0]
  input  logic [dad_pkg::CLASS_W-1:0]         s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // left[11:0], top[23:12], right[35:24], bottom[47:36], score[63:48]
  output logic [63:0]                         m_axis_tdata,
  // winning class[6:0]
  output logic [dad_pkg::CLASS_W-1:0]         m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dad_pkg::cfg_t cfg;
  dad_pkg::det_t det;
  logic          det_valid;

  logic fire;
  logic ready1;
  logic ready2;
  logic ready3;
  logic v2;
  logic v3;

  logic [dad_pkg::SCORE_W-1:0] score2;
  logic [dad_pkg::CLASS_W-1:0] class2;
  logic [dad_pkg::SCORE_W-1:0] score3;
  logic [dad_pkg::CLASS_W-1:0] class3;

  logic [dad_pkg::PIX_W-1:0] left;
  logic [dad_pkg::PIX_W-1:0] top;
  logic [dad_pkg::PIX_W-1:0] right;
  logic [dad_pkg::PIX_W-1:0] bottom;

  // Each stage takes new data when it is empty or its content moves on.
  assign ready3 = !v3 || m_axis_tready;
  assign ready2 = !v2 || ready3;
  assign ready1 = !det_valid || ready2;
  assign s_axis_tready = ready1;
  assign fire = s_axis_tvalid && ready1;

  dad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dad_winner u_winner (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .advance     (ready2),
    .center_x    (s_axis_tdata[15:0]),
    .center_y    (s_axis_tdata[31:16]),
    .box_width   (s_axis_tdata[47:32]),
    .box_height  (s_axis_tdata[63:48]),
    .class_score (s_axis_tdata[79:64]),
    .class_index (s_axis_tuser),
    .last_class  (s_axis_tlast),
    .cfg         (cfg),
    .det_valid   (det_valid),
    .det         (det)
  );

  dad_corner u_left (
    .clk (clk), .en_mul (ready2), .en_out (ready3), .add_size (1'b0),
    .center (det.center_x), .size (det.box_width), .pad (cfg.pad_x),
    .inv_scale (cfg.inverse_scale), .lim (cfg.frame_max_x), .corner (left)
  );

  dad_corner u_top (
    .clk (clk), .en_mul (ready2), .en_out (ready3), .add_size (1'b0),
    .center (det.center_y), .size (det.box_height), .pad (cfg.pad_y),
    .inv_scale (cfg.inverse_scale), .lim (cfg.frame_max_y), .corner (top)
  );

  dad_corner u_right (
    .clk (clk), .en_mul (ready2), .en_out (ready3), .add_size (1'b1),
    .center (det.center_x), .size (det.box_width), .pad (cfg.pad_x),
    .inv_scale (cfg.inverse_scale), .lim (cfg.frame_max_x), .corner (right)
  );

  dad_corner u_bottom (
    .clk (clk), .en_mul (ready2), .en_out (ready3), .add_size (1'b1),
    .center (det.center_y), .size (det.box_height), .pad (cfg.pad_y),
    .inv_scale (cfg.inverse_scale), .lim (cfg.frame_max_y), .corner (bottom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= det_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      score2 <= det.score;
      class2 <= det.win_class;
    end
    if (ready3) begin
      score3 <= score2;
      class3 <= class2;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {score3, bottom, right, top, left};
  assign m_axis_tuser  = class3;

endmodule

// ===== test/detection_anchor_decode_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for detection_anchor_decode: predicted detections versus the stream.
module detection_anchor_decode_test;

  localparam logic [dad_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 212;
  localparam int NUM_PHASES  = 8;
  localparam int DATA_W      = dad_pkg::CFG_DATA_W;
  localparam int CRD_W       = dad_pkg::COORD_W;
  localparam int SC_W        = dad_pkg::SCORE_W;
  localparam int CL_W        = dad_pkg::CLASS_W;

  typedef struct packed {
    logic signed [dad_pkg::COORD_W-1:0] center_x;
    logic signed [dad_pkg::COORD_W-1:0] center_y;
    logic signed [dad_pkg::COORD_W-1:0] box_width;
    logic signed [dad_pkg::COORD_W-1:0] box_height;
    logic [dad_pkg::SCORE_W-1:0]        class_score;
    logic [dad_pkg::CLASS_W-1:0]        class_index;
    logic                               is_last;
  } score_item_t;

  typedef struct packed {
    logic [dad_pkg::PIX_W-1:0]   left;
    logic [dad_pkg::PIX_W-1:0]   top;
    logic [dad_pkg::PIX_W-1:0]   right;
    logic [dad_pkg::PIX_W-1:0]   bottom;
    logic [dad_pkg::CLASS_W-1:0] win_class;
    logic [dad_pkg::SCORE_W-1:0] score;
  } detection_t;

  class detection_board;
    dad_pkg::cfg_t               regs;
    logic [dad_pkg::SCORE_W-1:0] lead_score;
    logic [dad_pkg::CLASS_W-1:0] lead_class;
    bit                          lead_found;
    detection_t                  detections_due[$];
    int                          errors;

    function new();
      regs.conf_threshold = dad_pkg::RST_CONF_THRESHOLD;
      regs.class_mask     = dad_pkg::RST_CLASS_MASK;
      regs.pad_x          = dad_pkg::RST_PAD;
      regs.pad_y          = dad_pkg::RST_PAD;
      regs.inverse_scale  = dad_pkg::RST_INVERSE_SCALE;
      regs.frame_max_x    = dad_pkg::RST_FRAME_MAX;
      regs.frame_max_y    = dad_pkg::RST_FRAME_MAX;
      lead_score = '0;
      lead_class = '0;
      lead_found = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [dad_pkg::CFG_IDX_W-1:0] idx,
                            logic [dad_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        dad_pkg::REG_CONF_THRESHOLD: regs.conf_threshold = value[dad_pkg::SCORE_W-1:0];
        dad_pkg::REG_CLASS_MASK:     regs.class_mask     = value[dad_pkg::MASK_W-1:0];
        dad_pkg::REG_PAD_X:          regs.pad_x          = value[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_PAD_Y:          regs.pad_y          = value[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_INVERSE_SCALE:  regs.inverse_scale  = value[dad_pkg::SCALE_W-1:0];
        dad_pkg::REG_FRAME_MAX_X:    regs.frame_max_x    = value[dad_pkg::PIX_W-1:0];
        dad_pkg::REG_FRAME_MAX_Y:    regs.frame_max_y    = value[dad_pkg::PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return detections_due.size();
    endfunction

    // The corner arrives at doubled scale, so the pad is shifted one bit further.
    function logic [dad_pkg::PIX_W-1:0] map_to_frame(longint doubled,
                                                     logic [dad_pkg::PIX_W-1:0] pad,
                                                     logic [dad_pkg::PIX_W-1:0] lim);
      longint offset;
      longint product;
      longint pixel;
      offset  = doubled - (longint'(pad) <<< (dad_pkg::COORD_FRAC_BITS + 1));
      product = offset * longint'(regs.inverse_scale);
      if (product <= 0) return '0;
      pixel = product >>> dad_pkg::PROD_SHIFT;
      if (pixel > longint'(lim)) pixel = longint'(lim);
      return pixel[dad_pkg::PIX_W-1:0];
    endfunction

    function void note_score(score_item_t it);
      detection_t det;
      bit         enabled;
      longint     cx;
      longint     cy;
      longint     bw;
      longint     bh;
      enabled = (it.class_index < dad_pkg::MASK_W) &&
                (it.class_index < dad_pkg::CLASS_COUNT) &&
                regs.class_mask[it.class_index[dad_pkg::MASK_IDX_W-1:0]];
      if (enabled && it.class_score > lead_score) begin
        lead_score = it.class_score;
        lead_class = it.class_index;
        lead_found = 1'b1;
      end
      if (it.is_last) begin
        if (lead_found && lead_score >= regs.conf_threshold) begin
          cx = longint'($signed(it.center_x));
          cy = longint'($signed(it.center_y));
          bw = longint'($signed(it.box_width));
          bh = longint'($signed(it.box_height));
          det.left      = map_to_frame(2 * cx - bw, regs.pad_x, regs.frame_max_x);
          det.top       = map_to_frame(2 * cy - bh, regs.pad_y, regs.frame_max_y);
          det.right     = map_to_frame(2 * cx + bw, regs.pad_x, regs.frame_max_x);
          det.bottom    = map_to_frame(2 * cy + bh, regs.pad_y, regs.frame_max_y);
          det.win_class = lead_class;
          det.score     = lead_score;
          detections_due.insert(detections_due.size(), det);
        end
        lead_score = '0;
        lead_class = '0;
        lead_found = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d, wanted %0d", name, got, want));
    endtask

    task check_detection(detection_t got);
      detection_t want;
      if (detections_due.size() == 0) begin
        report($sformatf("unexpected detection class %0d score %0d", got.win_class, got.score));
        return;
      end
      want = detections_due.pop_front();
      compare_field("left", got.left, want.left);
      compare_field("top", got.top, want.top);
      compare_field("right", got.right, want.right);
      compare_field("bottom", got.bottom, want.bottom);
      compare_field("class", got.win_class, want.win_class);
      compare_field("score", got.score, want.score);
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [79:0]                    s_axis_tdata = '0;
  logic [dad_pkg::CLASS_W-1:0]    s_axis_tuser = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [63:0]                    m_axis_tdata;
  logic [dad_pkg::CLASS_W-1:0]    m_axis_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit             no_gaps = 1'b0;
  int             idle_cycles = 0;
  detection_board sb;

  detection_anchor_decode dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin : sink
    detection_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.left      = m_axis_tdata[11:0];
      got.top       = m_axis_tdata[23:12];
      got.right     = m_axis_tdata[35:24];
      got.bottom    = m_axis_tdata[47:36];
      got.score     = m_axis_tdata[63:48];
      got.win_class = m_axis_tuser;
      sb.check_detection(got);
    end
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 21);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("detection_anchor_decode test failed");
        $finish;
      end
    end
  end

  function automatic score_item_t make_item(int cx, int cy, int bw, int bh, int sc, int ci,
                                            bit lst);
    score_item_t r;
    r.center_x    = cx[15:0];
    r.center_y    = cy[15:0];
    r.box_width   = bw[15:0];
    r.box_height  = bh[15:0];
    r.class_score = sc[15:0];
    r.class_index = ci[6:0];
    r.is_last     = lst;
    return r;
  endfunction

  // Valid stays high between back-to-back items; each cycle may idle at random.
  task automatic send_score(input score_item_t it);
    while (!no_gaps && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.class_score, it.box_height, it.box_width, it.center_y, it.center_x};
    s_axis_tuser  <= it.class_index;
    s_axis_tlast  <= it.is_last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_score(it);
  endtask

  task automatic load_reg(input logic [dad_pkg::CFG_IDX_W-1:0] idx,
                          input logic [dad_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  // A score-only transaction produces nothing, so allow the pipeline to empty after the queue does.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    score_item_t                    it;
    score_item_t                    box;
    logic [dad_pkg::CFG_DATA_W-1:0] mask;
    int                             thr;
    int                             px;
    int                             py;
    int                             scale;
    int                             fx;
    int                             fy;
    int                             n;
    int                             cls;
    int                             sent;
    int                             kind;
    int                             sc;
    int                             prev;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: threshold 26214, classes 0,1,2,3,5,7 enabled.
    send_score(make_item(32767, -32768, 32767, -32768, 65535, 0, 1));
    send_score(make_item(-32768, 32767, -32768, 32767, 0, 0, 1));
    // Equal scores: the earlier class keeps the win.
    send_score(make_item(5120, 3840, 1600, 1280, 40000, 1, 0));
    send_score(make_item(5120, 3840, 1600, 1280, 40000, 2, 0));
    send_score(make_item(5120, 3840, 1600, 1280, 30000, 3, 1));
    // A masked class and classes past the mask width never win.
    send_score(make_item(5120, 3840, 1600, 1280, 65535, 4, 0));
    send_score(make_item(5120, 3840, 1600, 1280, 30000, 5, 1));
    send_score(make_item(5120, 3840, 1600, 1280, 65535, 100, 0));
    send_score(make_item(5120, 3840, 1600, 1280, 65535, 64, 0));
    send_score(make_item(5120, 3840, 1600, 1280, 65535, 127, 1));
    send_score(make_item(5120, 3840, 1600, 1280, 26213, 0, 1));
    send_score(make_item(5120, 3840, 1600, 1280, 26214, 7, 1));
    // The box of the final item is the one decoded.
    send_score(make_item(0, 3840, 1600, 1280, 50000, 2, 0));
    send_score(make_item(9600, 9600, 3200, 3200, 20000, 3, 1));
    send_score(make_item(160, 160, 1600, 1600, 60000, 5, 1));
    drain();
    load_reg(REG_UNUSED, {$urandom, $urandom});
    load_reg(dad_pkg::REG_INVERSE_SCALE, '0);
    cfg_valid <= 1'b0;
    send_score(make_item(5120, 3840, 1600, 1280, 50000, 0, 1));
    drain();
    load_reg(dad_pkg::REG_CLASS_MASK, '0);
    cfg_valid <= 1'b0;
    send_score(make_item(5120, 3840, 1600, 1280, 65535, 0, 1));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          thr = 0; mask = '1; px = 0; py = 0; scale = 65536; fx = 4095; fy = 4095;
        end
        1: begin
          thr = 65535; mask = {$urandom, $urandom}; px = 4095; py = 4095;
          scale = 24'hFFFFFF; fx = 0; fy = 0;
        end
        2: begin
          thr = $urandom_range(10000, 40000); mask = {$urandom, $urandom} | 64'hFF;
          px = $urandom_range(0, 80); py = $urandom_range(0, 80);
          scale = $urandom_range(49152, 98304);
          fx = $urandom_range(300, 4095); fy = $urandom_range(300, 4095);
        end
        3: begin
          thr = 1; mask = 64'h8000_0000_0000_0001 | ({$urandom, $urandom} & {$urandom, $urandom});
          px = $urandom_range(0, 4095); py = $urandom_range(0, 4095);
          scale = $urandom_range(0, 24'hFFFFFF);
          fx = $urandom_range(0, 4095); fy = $urandom_range(0, 4095);
        end
        default: begin
          thr = $urandom_range(0, 50000);
          mask = {$urandom, $urandom} | {$urandom, $urandom};
          px = $urandom_range(0, 60); py = $urandom_range(0, 60);
          scale = $urandom_range(32768, 131072);
          fx = $urandom_range(200, 4095); fy = $urandom_range(200, 4095);
        end
      endcase
      load_reg(dad_pkg::REG_CONF_THRESHOLD, DATA_W'(thr));
      load_reg(dad_pkg::REG_CLASS_MASK, mask);
      load_reg(dad_pkg::REG_PAD_X, DATA_W'(px));
      load_reg(dad_pkg::REG_PAD_Y, DATA_W'(py));
      load_reg(dad_pkg::REG_INVERSE_SCALE, DATA_W'(scale));
      load_reg(dad_pkg::REG_FRAME_MAX_X, DATA_W'(fx));
      load_reg(dad_pkg::REG_FRAME_MAX_Y, DATA_W'(fy));
      cfg_valid <= 1'b0;
      no_gaps = (phase == 2);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        n = (kind < 4) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        if (kind < 25) begin
          box = make_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0, 0);
        end else begin
          box = make_item($urandom_range(0, 16 * 720), $urandom_range(0, 16 * 720),
                          $urandom_range(0, 16 * 400), $urandom_range(0, 16 * 400), 0, 0, 0);
        end
        cls  = $urandom_range(0, 3);
        prev = 0;
        for (int i = 0; i < n; i++) begin
          it = box;
          // A few anchors move their box from item to item.
          if (kind >= 95) begin
            it.center_x   = CRD_W'($urandom_range(0, 65535));
            it.center_y   = CRD_W'($urandom_range(0, 65535));
            it.box_width  = CRD_W'($urandom_range(0, 65535));
            it.box_height = CRD_W'($urandom_range(0, 65535));
          end
          if (kind >= 85 && kind < 95)
            it.class_index = CL_W'($urandom_range(0, 127));
          else
            it.class_index = CL_W'(cls);
          case ($urandom_range(9))
            0: sc = 0;
            1: sc = prev;
            2, 3, 4: begin
              sc = int'(sb.regs.conf_threshold) + int'($urandom_range(0, 400)) - 200;
              if (sc < 0) sc = 0;
              if (sc > 65535) sc = 65535;
            end
            5, 6: sc = 65535 - int'($urandom_range(0, 300));
            default: sc = $urandom_range(0, 65535);
          endcase
          it.class_score = SC_W'(sc);
          // Broken anchors end early at random points.
          if (kind >= 80 && kind < 85)
            it.is_last = (i == n - 1) || ($urandom_range(3) == 0);
          else
            it.is_last = (i == n - 1);
          send_score(it);
          prev = sc;
          cls = cls + $urandom_range(1, 3);
          if (cls > 127) cls = 127;
        end
        sent += n;
      end
      no_gaps = 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("detection_anchor_decode test passed");
    else
      $display("detection_anchor_decode test failed");
    $finish;
  end

endmodule
